/* sv/bsm_pkg.sv */
`default_nettype none
package bsm_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_VECTOR = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BANK_SW   = 2'd0;
  localparam logic [1:0] CFG_CARD_SW   = 2'd1;
  localparam logic [1:0] CFG_SHADOW_SW = 2'd2;

  // Bank switch bits
  localparam int BS_ALTZP   = 0;
  localparam int BS_AUXRD   = 1;
  localparam int BS_AUXWR   = 2;
  localparam int BS_STORE80 = 3;
  localparam int BS_PAGE2   = 4;
  localparam int BS_HIRES   = 5;

  // Language card bits
  localparam int CS_BANK2  = 0;
  localparam int CS_READ   = 1;
  localparam int CS_WRITE  = 2;
  localparam int CS_LOWCRD = 3;

  // Shadow enable bits
  localparam int SS_TEXT   = 0;
  localparam int SS_TEXT2  = 1;
  localparam int SS_HIRES1 = 2;
  localparam int SS_HIRES2 = 3;
  localparam int SS_AUX    = 4;
  localparam int SS_SUPER  = 5;

  typedef enum logic [2:0] {
    AK_MEM_RD  = 3'd0,
    AK_MEM_WR  = 3'd1,
    AK_IO_RD   = 3'd2,
    AK_IO_WR   = 3'd3,
    AK_DISCARD = 3'd4
  } access_kind_t;

  typedef struct packed {
    logic [5:0] bank_sw;
    logic [3:0] card_sw;
    logic [5:0] shadow_sw;
  } switches_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  bank;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    access_kind_t access_kind;
    logic [23:0]  target_address;
    logic         shadow_enable;
    logic [23:0]  shadow_address;
    logic [7:0]   data_out;
  } result_t;

endpackage
`default_nettype wire

/* sv/bsm_map.sv */
`default_nettype none
// Page translation: pure combinational map of one access.
module bsm_map (
  input  wire bsm_pkg::access_t   acc,
  input  wire bsm_pkg::switches_t sw,
  output bsm_pkg::result_t        res
);

  logic        wr;
  logic [7:0]  bank_eff;
  logic [7:0]  hi;
  logic [7:0]  lo;
  logic [15:0] lp;
  logic        aux;
  logic        card_en;
  logic [7:0]  card_off;
  logic        use_card;
  logic        card_rom;
  logic [7:0]  card_src;
  logic [7:0]  card_hi;
  logic        is_io;
  logic        sel;
  logic [15:0] pp;
  logic        shad;
  logic [5:0]  ss;

  always_comb begin
    wr       = acc.kind[1];
    bank_eff = (acc.kind == bsm_pkg::KIND_VECTOR) ? 8'hFF : acc.bank;
    hi       = acc.address[15:8];
    lo       = acc.address[7:0];
    lp       = {bank_eff, hi};
    aux      = wr ? sw.bank_sw[bsm_pkg::BS_AUXWR] : sw.bank_sw[bsm_pkg::BS_AUXRD];

    // Language card window
    card_en  = wr ? sw.card_sw[bsm_pkg::CS_WRITE] : sw.card_sw[bsm_pkg::CS_READ];
    card_off = sw.card_sw[bsm_pkg::CS_BANK2] ? 8'h00 : 8'h10;
    use_card = (hi >= 8'hC0) &&
               ((((bank_eff == 8'h00) || (bank_eff == 8'h01)) &&
                 sw.card_sw[bsm_pkg::CS_LOWCRD]) ||
                (bank_eff == 8'hE0) || (bank_eff == 8'hE1));
    card_rom = (hi < 8'hD0) || !card_en;
    card_src = (bank_eff == 8'h00) ? {7'd0, sw.bank_sw[bsm_pkg::BS_ALTZP]} : bank_eff;
    card_hi  = (hi < 8'hE0) ? (hi - card_off) : hi;

    // Bank 00 main/aux select
    priority if (hi < 8'h02) begin
      sel = sw.bank_sw[bsm_pkg::BS_ALTZP];
    end else if ((hi >= 8'h04) && (hi < 8'h08) && sw.bank_sw[bsm_pkg::BS_STORE80]) begin
      sel = sw.bank_sw[bsm_pkg::BS_PAGE2];
    end else if ((hi >= 8'h20) && (hi < 8'h40) && sw.bank_sw[bsm_pkg::BS_STORE80] &&
                 sw.bank_sw[bsm_pkg::BS_HIRES]) begin
      sel = sw.bank_sw[bsm_pkg::BS_PAGE2];
    end else begin
      sel = aux;
    end

    is_io = 1'b0;
    if (use_card) begin
      is_io = (hi == 8'hC0);
      pp    = card_rom ? {8'hFF, hi} : {card_src, card_hi};
    end else if (bank_eff == 8'h00) begin
      pp = {7'd0, sel, hi};
    end else begin
      pp = lp;
    end

    // Shadowed video pages, by logical page
    ss   = sw.shadow_sw;
    shad = 1'b0;
    if (bank_eff == 8'h00) begin
      if ((hi >= 8'h04) && (hi < 8'h08)) shad = ss[bsm_pkg::SS_TEXT];
      else if ((hi >= 8'h08) && (hi < 8'h0C)) shad = ss[bsm_pkg::SS_TEXT2];
      else if ((hi >= 8'h20) && (hi < 8'h40)) shad = ss[bsm_pkg::SS_HIRES1];
      else if ((hi >= 8'h60) && (hi < 8'h80)) shad = ss[bsm_pkg::SS_HIRES2];
    end else if (bank_eff == 8'h01) begin
      if ((hi >= 8'h04) && (hi < 8'h08)) shad = ss[bsm_pkg::SS_TEXT];
      else if ((hi >= 8'h08) && (hi < 8'h0C)) shad = ss[bsm_pkg::SS_TEXT2];
      else if ((hi >= 8'h20) && (hi < 8'h40))
        shad = (ss[bsm_pkg::SS_HIRES1] && ss[bsm_pkg::SS_AUX]) || ss[bsm_pkg::SS_SUPER];
      else if ((hi >= 8'h40) && (hi < 8'h60))
        shad = (ss[bsm_pkg::SS_HIRES2] && ss[bsm_pkg::SS_AUX]) || ss[bsm_pkg::SS_SUPER];
      else if ((hi >= 8'h60) && (hi < 8'hA0))
        shad = ss[bsm_pkg::SS_AUX] || ss[bsm_pkg::SS_SUPER];
    end

    res.shadow_enable  = 1'b0;
    res.shadow_address = 24'd0;
    res.data_out       = 8'd0;
    if (is_io) begin
      res.access_kind    = wr ? bsm_pkg::AK_IO_WR : bsm_pkg::AK_IO_RD;
      res.target_address = {lp, lo};
      res.data_out       = wr ? acc.write_data : 8'd0;
    end else begin
      res.target_address = {pp, lo};
      if (!wr) begin
        res.access_kind = bsm_pkg::AK_MEM_RD;
      end else if (pp[15:10] == 6'h3F) begin
        // ROM from page FC00 up: drop the write
        res.access_kind = bsm_pkg::AK_DISCARD;
      end else begin
        res.access_kind    = bsm_pkg::AK_MEM_WR;
        res.data_out       = acc.write_data;
        res.shadow_enable  = shad;
        res.shadow_address = shad ? {(bank_eff | 8'hE0), hi, lo} : 24'd0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/bank_switch_shadow_mapper_core.sv */
`default_nettype none
// Bank switch / shadow address mapper.
// An accepted access passes through the input register and then the result register
// before out_tvalid rises for its result.
// Throughput: one access per cycle while out_tready holds; a full result register still
// takes a new input when the downstream side accepts in the same cycle.
// Reset (rst_n low, synchronous): both stages emptied, all switch registers cleared to 0.
module bank_switch_shadow_mapper_core (
  input  wire         clk,
  input  wire         rst_n,

  // Configuration write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [5:0]  cfg_wdata,

  // Access stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // bank[7:0], address[23:8], write_data[31:24]
  input  wire  [1:0]  in_tuser,   // kind[1:0]

  // Result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // target_address[23:0], shadow_enable[24],
                                  // shadow_address[48:25], data_out[56:49], zero[63:57]
  output logic [2:0]  out_tuser   // access_kind[2:0]
);

  // Soft-switch registers
  logic [5:0] bank_sw_r;
  logic [3:0] card_sw_r;
  logic [5:0] shadow_sw_r;

  bsm_pkg::switches_t sw;

  // Input stage
  logic             s1_valid_r;
  bsm_pkg::access_t s1_acc_r;

  // Result stage
  logic             out_valid_r;
  bsm_pkg::result_t out_res_r;
  bsm_pkg::result_t res_nxt;

  logic out_load;
  logic s1_load;

  // Switch writes; index 3 is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sw_r   <= 6'd0;
      card_sw_r   <= 4'd0;
      shadow_sw_r <= 6'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsm_pkg::CFG_BANK_SW:   bank_sw_r   <= cfg_wdata;
        bsm_pkg::CFG_CARD_SW:   card_sw_r   <= cfg_wdata[3:0];
        bsm_pkg::CFG_SHADOW_SW: shadow_sw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sw = '{bank_sw: bank_sw_r, card_sw: card_sw_r, shadow_sw: shadow_sw_r};

  // Result register frees when empty or when its transfer completes;
  // the input stage moves forward whenever the result register can load.
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_load;
  assign s1_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_acc_r <= '{kind:       in_tuser,
                    bank:       in_tdata[7:0],
                    address:    in_tdata[23:8],
                    write_data: in_tdata[31:24]};
    end
  end

  // Translation between the two registers
  bsm_map u_map (
    .acc (s1_acc_r),
    .sw  (sw),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.access_kind;
  assign out_tdata  = {7'd0,
                       out_res_r.data_out,
                       out_res_r.shadow_address,
                       out_res_r.shadow_enable,
                       out_res_r.target_address};

endmodule
`default_nettype wire
